### design/comment_string_lexer_defines.svh
// assertion macros for the comment and string lexer checker
// no dependencies; included by files that assert
`ifndef COMMENT_STRING_LEXER_DEFINES_SVH
`define COMMENT_STRING_LEXER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/csl_pkg.sv
// shared types and constants for the comment and string lexer
// no dependencies
package csl_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int LEN_OUT_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] LENGTH_CAP =
    (LENGTH_BITS > LEN_OUT_BITS) ? LENGTH_BITS'({LEN_OUT_BITS{1'b1}}) : '1;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_ERROR   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    KIND_COMMENT_BYTE = 3'd0,
    KIND_STRING_BYTE  = 3'd1,
    KIND_COMMENT_END  = 3'd2,
    KIND_STRING_END   = 3'd3,
    KIND_INVALID      = 3'd4,
    KIND_EXHAUSTED    = 3'd5
  } kind_t;

  typedef struct packed {
    logic                    emit;
    kind_t                   kind;
    logic [7:0]              char_value;
    logic [LEN_OUT_BITS-1:0] token_length;
  } result_t;

endpackage

### design/comment_string_lexer.sv
// Lexer for line comments and quoted strings, one source word per cycle. A word passes
// an input register, then the mode logic, then the result register; a new word is taken
// every cycle while the result side keeps up, and a waiting result stalls the input only
// when the input register is also full. A result is presented from the result register
// once its word has left the input register.
// Whitespace, openers and a backslash inside a string give no result. After an invalid
// byte every later word reports invalid until reset. Token lengths saturate at 65535.
// Depends on csl_pkg and csl_step.
module comment_string_lexer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_source_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_result_kind,
  output logic [7:0] out_char_value,
  output logic [csl_pkg::LEN_OUT_BITS-1:0] out_token_length
);
  import csl_pkg::*;

  logic                    in_vld_r;
  logic [7:0]              in_byte_r;
  logic                    in_eoi_r;
  mode_t                   mode_r, mode_nxt;
  logic [LENGTH_BITS-1:0]  count_r, count_nxt;
  logic                    out_vld_r;
  kind_t                   out_kind_r;
  logic [7:0]              out_char_r;
  logic [LEN_OUT_BITS-1:0] out_len_r;
  result_t                 result;
  logic                    advance;
  logic                    in_take;

  csl_step u_step (
    .mode         (mode_r),
    .count        (count_r),
    .source_byte  (in_byte_r),
    .end_of_input (in_eoi_r),
    .mode_nxt     (mode_nxt),
    .count_nxt    (count_nxt),
    .result       (result)
  );

  assign advance = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r <= MODE_IDLE;
      count_r <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= in_vld_r && result.emit;
        if (in_vld_r) begin
          mode_r <= mode_nxt;
          count_r <= count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_source_byte;
      in_eoi_r <= in_end_of_input;
    end
    if (advance && in_vld_r) begin
      out_kind_r <= result.kind;
      out_char_r <= result.char_value;
      out_len_r <= result.token_length;
    end
  end

  assign out_valid = out_vld_r;
  assign out_result_kind = out_kind_r;
  assign out_char_value = out_char_r;
  assign out_token_length = out_len_r;

endmodule

### design/csl_step.sv
// next-state and result logic for one word of the lexer
// depends on csl_pkg
module csl_step (
  input  csl_pkg::mode_t                       mode,
  input  logic [csl_pkg::LENGTH_BITS-1:0]      count,
  input  logic [7:0]                           source_byte,
  input  logic                                 end_of_input,
  output csl_pkg::mode_t                       mode_nxt,
  output logic [csl_pkg::LENGTH_BITS-1:0]      count_nxt,
  output csl_pkg::result_t                     result
);
  import csl_pkg::*;

  logic [LENGTH_BITS-1:0] count_inc;

  assign count_inc = (count < LENGTH_CAP) ? count + 1'b1 : count;

  always_comb begin
    mode_nxt = mode;
    count_nxt = count;
    result = '{emit: 1'b0, kind: KIND_INVALID, char_value: 8'h00, token_length: '0};
    if (mode == MODE_IDLE || mode == MODE_COMMENT || mode == MODE_STRING ||
        mode == MODE_ESCAPE) begin
      if (end_of_input) begin
        result.emit = 1'b1;
        result.kind = KIND_EXHAUSTED;
      end else begin
        case (mode)
          MODE_IDLE: begin
            if (source_byte == CH_SPACE || source_byte == CH_TAB || source_byte == CH_NL) begin
              mode_nxt = MODE_IDLE;
            end else if (source_byte == CH_HASH) begin
              mode_nxt = MODE_COMMENT;
              count_nxt = '0;
            end else if (source_byte == CH_QUOTE) begin
              mode_nxt = MODE_STRING;
              count_nxt = '0;
            end else begin
              mode_nxt = MODE_ERROR;
              result.emit = 1'b1;
            end
          end
          MODE_COMMENT: begin
            result.emit = 1'b1;
            if (source_byte == CH_NL) begin
              mode_nxt = MODE_IDLE;
              count_nxt = '0;
              result.kind = KIND_COMMENT_END;
              result.token_length = LEN_OUT_BITS'(count);
            end else begin
              count_nxt = count_inc;
              result.kind = KIND_COMMENT_BYTE;
              result.char_value = source_byte;
            end
          end
          MODE_STRING: begin
            if (source_byte == CH_QUOTE) begin
              mode_nxt = MODE_IDLE;
              count_nxt = '0;
              result.emit = 1'b1;
              result.kind = KIND_STRING_END;
              result.token_length = LEN_OUT_BITS'(count);
            end else if (source_byte == CH_BSLASH) begin
              mode_nxt = MODE_ESCAPE;
            end else if (source_byte == CH_NL) begin
              mode_nxt = MODE_ERROR;
              result.emit = 1'b1;
            end else begin
              count_nxt = count_inc;
              result.emit = 1'b1;
              result.kind = KIND_STRING_BYTE;
              result.char_value = source_byte;
            end
          end
          default: begin
            result.emit = 1'b1;
            mode_nxt = MODE_STRING;
            if (source_byte == CH_BSLASH || source_byte == CH_QUOTE) begin
              count_nxt = count_inc;
              result.kind = KIND_STRING_BYTE;
              result.char_value = source_byte;
            end else if (source_byte == CH_N) begin
              count_nxt = count_inc;
              result.kind = KIND_STRING_BYTE;
              result.char_value = CH_NL;
            end else if (source_byte == CH_T) begin
              count_nxt = count_inc;
              result.kind = KIND_STRING_BYTE;
              result.char_value = CH_TAB;
            end else begin
              mode_nxt = MODE_ERROR;
            end
          end
        endcase
      end
    end else begin
      mode_nxt = MODE_ERROR;
      result.emit = 1'b1;
    end
  end

endmodule

### design/csl_checker.sv
// port-level checks on the lexer result channel, bound to the top level
// depends on csl_pkg and comment_string_lexer_defines.svh
`include "comment_string_lexer_defines.svh"

module csl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_result_kind,
  input logic [7:0] out_char_value,
  input logic [csl_pkg::LEN_OUT_BITS-1:0] out_token_length
);
  import csl_pkg::*;

  logic err_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_result_kind == KIND_INVALID) begin
      err_seen_r <= 1'b1;
    end
  end

  `CSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "word dropped under stall")
  `CSL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_result_kind) && $stable(out_char_value) && $stable(out_token_length), "payload moved under stall")
  `CSL_ASSERT_NOW(a_byte_no_len, clk, rst_n, out_valid && (out_result_kind == KIND_COMMENT_BYTE || out_result_kind == KIND_STRING_BYTE), out_token_length == '0, "byte word with length")
  `CSL_ASSERT_NOW(a_other_no_char, clk, rst_n, out_valid && out_result_kind != KIND_COMMENT_BYTE && out_result_kind != KIND_STRING_BYTE, out_char_value == 8'h00, "non-byte word with char")
  `CSL_ASSERT_NOW(a_error_sticky, clk, rst_n, out_valid && err_seen_r, out_result_kind == KIND_INVALID, "left error before reset")

endmodule

bind comment_string_lexer csl_checker u_csl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_kind  (out_result_kind),
  .out_char_value   (out_char_value),
  .out_token_length (out_token_length)
);

### bench/tb_comment_string_lexer.sv
// testbench for comment_string_lexer: directed and random byte streams with random idling
// predicts every result word in-bench and checks each one in order; depends on csl_pkg
`timescale 1ns / 1ps

module tb_comment_string_lexer;
  import csl_pkg::*;

  typedef struct {
    kind_t                   kind;
    logic [7:0]              ch;
    logic [LEN_OUT_BITS-1:0] len;
  } lex_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              in_source_byte = 8'h00;
  logic                    in_end_of_input = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [2:0]              out_result_kind;
  logic [7:0]              out_char_value;
  logic [LEN_OUT_BITS-1:0] out_token_length;

  mode_t                   lex_mode = MODE_IDLE;
  logic [LENGTH_BITS-1:0]  open_len = '0;
  lex_word_t               lexed_q[$];
  int                      mismatches = 0;
  int                      words_sent = 0;
  int                      hold_cnt = 0;
  bit                      quiet = 1'b0;

  comment_string_lexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_source_byte   (in_source_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_char_value   (out_char_value),
    .out_token_length (out_token_length)
  );

  always #6 clk = ~clk;

  initial begin
    #12_000_000;
    $display("FAIL comment_string_lexer");
    $finish;
  end

  function automatic void lex_byte(input logic [7:0] c, input logic eoi);
    lex_word_t w;
    bit        hit;
    bit        grow;
    w.kind = KIND_INVALID;
    w.ch   = '0;
    w.len  = '0;
    hit    = 1'b1;
    grow   = 1'b0;
    if (lex_mode == MODE_ERROR) begin
      w.kind = KIND_INVALID;
    end else if (eoi) begin
      w.kind = KIND_EXHAUSTED;
    end else begin
      case (lex_mode)
        MODE_IDLE: begin
          if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
            hit = 1'b0;
          end else if (c == CH_HASH) begin
            lex_mode = MODE_COMMENT;
            open_len = '0;
            hit = 1'b0;
          end else if (c == CH_QUOTE) begin
            lex_mode = MODE_STRING;
            open_len = '0;
            hit = 1'b0;
          end else begin
            lex_mode = MODE_ERROR;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            w.kind = KIND_COMMENT_END;
            w.len = LEN_OUT_BITS'(open_len);
            lex_mode = MODE_IDLE;
            open_len = '0;
          end else begin
            w.kind = KIND_COMMENT_BYTE;
            w.ch = c;
            grow = 1'b1;
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            w.kind = KIND_STRING_END;
            w.len = LEN_OUT_BITS'(open_len);
            lex_mode = MODE_IDLE;
            open_len = '0;
          end else if (c == CH_BSLASH) begin
            lex_mode = MODE_ESCAPE;
            hit = 1'b0;
          end else if (c == CH_NL) begin
            lex_mode = MODE_ERROR;
          end else begin
            w.kind = KIND_STRING_BYTE;
            w.ch = c;
            grow = 1'b1;
          end
        end
        default: begin
          lex_mode = MODE_STRING;
          w.kind = KIND_STRING_BYTE;
          grow = 1'b1;
          if (c == CH_BSLASH || c == CH_QUOTE) begin
            w.ch = c;
          end else if (c == CH_N) begin
            w.ch = CH_NL;
          end else if (c == CH_T) begin
            w.ch = CH_TAB;
          end else begin
            w.kind = KIND_INVALID;
            grow = 1'b0;
            lex_mode = MODE_ERROR;
          end
        end
      endcase
    end
    if (grow && open_len < LENGTH_CAP) open_len = open_len + 1'b1;
    if (hit) lexed_q.push_back(w);
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_word();
    lex_word_t w;
    if (lexed_q.size() == 0) begin
      report($sformatf("unexpected word kind %0d", out_result_kind));
    end else begin
      w = lexed_q.pop_front();
      if (out_result_kind !== w.kind)
        report($sformatf("kind %0d, want %0d", out_result_kind, w.kind));
      if (out_char_value !== w.ch)
        report($sformatf("char_value %h, want %h", out_char_value, w.ch));
      if (out_token_length !== w.len)
        report($sformatf("token_length %0d, want %0d", out_token_length, w.len));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_word();
      hold_cnt = quiet ? 0 : $urandom_range(0, 15);
    end else if (hold_cnt > 0) begin
      hold_cnt--;
    end
    out_stall <= (hold_cnt != 0);
  end

  task automatic send_word(input logic [7:0] c, input logic eoi);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_source_byte  <= c;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall !== 1'b0);
    lex_byte(c, eoi);
    words_sent++;
  endtask

  task automatic send_eoi();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (lexed_q.size() != 0);
  endtask

  function automatic logic [7:0] plain_string_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || c == CH_BSLASH || c == CH_NL);
    return c;
  endfunction

  function automatic logic [7:0] comment_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
    return c;
  endfunction

  function automatic logic [7:0] escape_byte();
    case ($urandom_range(0, 3))
      0: return CH_BSLASH;
      1: return CH_QUOTE;
      2: return CH_N;
      default: return CH_T;
    endcase
  endfunction

  task automatic test_whitespace();
    send_word(CH_SPACE, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_NL, 1'b0);
  endtask

  task automatic test_comment();
    send_word(CH_HASH, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_eoi();
    send_word(CH_NL, 1'b0);
  endtask

  // escapes, end marks inside a string, closing quote followed by another opener
  task automatic test_string();
    send_word(CH_QUOTE, 1'b0);
    send_eoi();
    send_word(CH_BSLASH, 1'b0);
    send_eoi();
    send_word(CH_BSLASH, 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_word(CH_QUOTE, 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_word(CH_N, 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_word(CH_T, 1'b0);
    send_word(CH_QUOTE, 1'b0);
    send_word(CH_QUOTE, 1'b0);
    send_word(CH_QUOTE, 1'b0);
    send_eoi();
  endtask

  task automatic test_random();
    int  first;
    int  n;
    bit  drained;
    first = words_sent;
    drained = 1'b0;
    while (words_sent - first < 400) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (!drained && words_sent - first > 200) begin
        wait_drained();
        drained = 1'b1;
      end
      case ($urandom_range(0, 5))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
              0: send_word(CH_SPACE, 1'b0);
              1: send_word(CH_TAB, 1'b0);
              default: send_word(CH_NL, 1'b0);
            endcase
          end
        end
        1, 2: begin
          send_word(CH_HASH, 1'b0);
          n = $urandom_range(0, 12);
          repeat (n) begin
            if ($urandom_range(0, 9) == 0) send_eoi();
            else send_word(comment_byte(), 1'b0);
          end
          send_word(CH_NL, 1'b0);
        end
        3, 4: begin
          send_word(CH_QUOTE, 1'b0);
          n = $urandom_range(0, 12);
          repeat (n) begin
            case ($urandom_range(0, 9))
              6, 7: begin
                send_word(CH_BSLASH, 1'b0);
                send_word(escape_byte(), 1'b0);
              end
              8: begin
                send_word(CH_BSLASH, 1'b0);
                send_eoi();
                send_word(escape_byte(), 1'b0);
              end
              9: send_eoi();
              default: send_word(plain_string_byte(), 1'b0);
            endcase
          end
          send_word(CH_QUOTE, 1'b0);
        end
        default: send_eoi();
      endcase
    end
    quiet = 1'b0;
  endtask

  // the error mode holds until reset, so one way into it is picked per run
  task automatic test_error();
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0: begin
        do c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_HASH || c == CH_QUOTE);
        send_word(c, 1'b0);
      end
      1: begin
        do c = 8'($urandom_range(0, 255));
        while (c == CH_BSLASH || c == CH_QUOTE || c == CH_N || c == CH_T);
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(c, 1'b0);
      end
      default: begin
        send_word(CH_QUOTE, 1'b0);
        send_word(plain_string_byte(), 1'b0);
        send_word(CH_NL, 1'b0);
      end
    endcase
    repeat (16) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_whitespace();
    test_comment();
    test_string();
    test_random();
    test_error();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS comment_string_lexer");
    end else begin
      $display("FAIL comment_string_lexer");
    end
    $finish;
  end

endmodule
